>>> hdl/robin_hood_hash_table_macros.svh
// Assertion macros for the hash table checker.
// Used by rhh_checker.sv; no other dependencies.
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define RHH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rhh_pkg.sv
// Shared types and codes for the Robin Hood hash table.
// No dependencies.
`timescale 1ns / 1ps

package rhh_pkg;

    localparam logic [1:0] OP_GET  = 2'd0;
    localparam logic [1:0] OP_PUT  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] STATUS_FOUND       = 3'd0;
    localparam logic [2:0] STATUS_INSERTED    = 3'd1;
    localparam logic [2:0] STATUS_NOT_FOUND   = 3'd2;
    localparam logic [2:0] STATUS_DELETED     = 3'd3;
    localparam logic [2:0] STATUS_LOAD_FULL   = 3'd4;
    localparam logic [2:0] STATUS_PROBE_LIMIT = 3'd5;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    localparam logic REG_LOAD_LIMIT  = 1'b0;
    localparam logic REG_PROBE_LIMIT = 1'b1;

    localparam logic [16:0] LOAD_LIMIT_RESET  = 17'd768;
    localparam logic [7:0]  PROBE_LIMIT_RESET = 8'd128;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int MIX_SHIFT = 33;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_RD,
        S_INS_CMP
    } state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_MOD
    } hash_state_t;

endpackage

>>> hdl/rhh_hash.sv
// Iterative murmur finalizer and home-slot reduction on one 32x32 multiplier.
// Depends on rhh_pkg.
`timescale 1ns / 1ps

module rhh_hash #(
    parameter int SLOTS = 1024,
    parameter int IDX_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      key,
    output logic             done,
    output logic [IDX_W-1:0] home
);
    import rhh_pkg::*;

    localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [63:0] TWO32  = 64'h1_0000_0000;
    localparam logic [31:0] FOLD_K = 32'(TWO32 % 64'(SLOTS));
    localparam logic [31:0] RECIP  = 32'(TWO32 / 64'(SLOTS));
    localparam logic [31:0] DIVR   = 32'(SLOTS);
    localparam logic [5:0]  STEP_RECIP = 6'd4;
    localparam logic [5:0]  STEP_BACK  = 6'd5;
    localparam logic [5:0]  STEP_LAST  = 6'd6;

    hash_state_t state_reg, state_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  ph_reg, ph_next;
    logic        rnd_reg, rnd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [IDX_W-1:0] home_reg, home_next;

    logic [63:0] cst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod, sum, mixed;
    logic [31:0] red;
    logic        last_mul;

    assign cst   = rnd_reg ? MIX_C2 : MIX_C1;
    assign prod  = mul_a * mul_b;
    assign sum   = (ph_reg == 2'd0) ? prod : acc_reg + {prod[31:0], 32'd0};
    assign mixed = sum ^ (sum >> MIX_SHIFT);
    assign last_mul = (ph_reg == 2'd2) && rnd_reg;
    assign red   = (x_reg[31:0] >= DIVR) ? x_reg[31:0] - DIVR : x_reg[31:0];

    always_comb
    begin
        if (state_reg == H_MOD)
        begin
            priority if (cnt_reg < STEP_RECIP)
            begin
                mul_a = x_reg[63:32];
                mul_b = FOLD_K;
            end
            else if (cnt_reg == STEP_RECIP)
            begin
                mul_a = x_reg[31:0];
                mul_b = RECIP;
            end
            else
            begin
                mul_a = acc_reg[63:32];
                mul_b = DIVR;
            end
        end
        else
        begin
            mul_a = (ph_reg == 2'd1) ? x_reg[63:32] : x_reg[31:0];
            mul_b = (ph_reg == 2'd2) ? cst[63:32] : cst[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE:  if (start) state_next = H_MUL;
            H_MUL:   if (last_mul) state_next = POW2 ? H_IDLE : H_MOD;
            H_MOD:   if (cnt_reg == STEP_LAST) state_next = H_IDLE;
            default: state_next = H_IDLE;
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        acc_next  = acc_reg;
        ph_next   = ph_reg;
        rnd_next  = rnd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        home_next = home_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_next   = key ^ (key >> MIX_SHIFT);
                    ph_next  = 2'd0;
                    rnd_next = 1'b0;
                end
            end
            H_MUL:
            begin
                acc_next = sum;
                if (ph_reg == 2'd2)
                begin
                    x_next   = mixed;
                    ph_next  = 2'd0;
                    rnd_next = 1'b1;
                    if (rnd_reg)
                    begin
                        cnt_next = 6'd0;
                        if (POW2)
                        begin
                            done_next = 1'b1;
                            home_next = mixed[IDX_W-1:0];
                        end
                    end
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            H_MOD:
            begin
                // four folds of the upper word by 2^32 mod SLOTS, then a
                // reciprocal quotient, back-multiply and one corrective subtract
                cnt_next = cnt_reg + 6'd1;
                priority if (cnt_reg < STEP_RECIP)
                begin
                    x_next = prod + {32'd0, x_reg[31:0]};
                end
                else if (cnt_reg == STEP_RECIP)
                begin
                    acc_next = prod;
                end
                else if (cnt_reg == STEP_BACK)
                begin
                    x_next = {32'd0, x_reg[31:0] - prod[31:0]};
                end
                else
                begin
                    done_next = 1'b1;
                    home_next = red[IDX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            ph_reg    <= 2'd0;
            rnd_reg   <= 1'b0;
            cnt_reg   <= 6'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        home_reg <= home_next;
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

>>> hdl/rhh_slot_mem.sv
// Slot storage: marks, keys, values and probe distances, one port with a shared write and read address.
// Depends on rhh_pkg.
`timescale 1ns / 1ps

module rhh_slot_mem #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      addr,
    input  logic [1:0]            wr_mark,
    input  logic [63:0]           wr_key,
    input  logic [VALUE_BITS-1:0] wr_val,
    input  logic [7:0]            wr_dist,
    output logic [1:0]            rd_mark,
    output logic [63:0]           rd_key,
    output logic [VALUE_BITS-1:0] rd_val,
    output logic [7:0]            rd_dist
);
    import rhh_pkg::*;

    logic [1:0]            mark_mem [SLOTS];
    logic [63:0]           key_mem  [SLOTS];
    logic [VALUE_BITS-1:0] val_mem  [SLOTS];
    logic [7:0]            dist_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mark_mem[addr] <= wr_mark;
            key_mem[addr]  <= wr_key;
            val_mem[addr]  <= wr_val;
            dist_mem[addr] <= wr_dist;
        end
        rd_mark <= mark_mem[addr];
        rd_key  <= key_mem[addr];
        rd_val  <= val_mem[addr];
        rd_dist <= dist_mem[addr];
    end

endmodule

>>> hdl/robin_hood_hash_table.sv
// Robin Hood hash table top level: sequencer, config registers, result registers.
// Depends on rhh_pkg, rhh_hash, rhh_slot_mem.
//
// Usage: raise start with op, key and new_value while busy is low; the request
// is taken on that edge and busy stays high until the result. The result shows
// on status, read_value and slot_index for one cycle with done high; the
// receiver cannot stall it and a new start may come in that same cycle.
// Per request: the hash (plus the H_MOD reduction when SLOTS is not a power of
// two), then a read state and a compare state per slot probed by the lookup,
// and the same per slot walked on insert; the single slot memory read port
// sets the per-probe cost.
// Reset: entry count clears, load_limit and probe_limit return to 768 and 128,
// then a clearing pass marks all SLOTS slots empty, one per cycle, with busy high.
// Config writes (cfg_write, cfg_index, cfg_data) are taken at any edge, but
// only while idle by contract.
`timescale 1ns / 1ps

module robin_hood_hash_table #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [63:0] key,
    input  logic [31:0] new_value,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] read_value,
    output logic [15:0] slot_index,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import rhh_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next, home_reg, home_next, pat_reg, pat_next;
    logic [8:0]  d_reg, d_next;
    logic [63:0] ck_reg, ck_next;
    logic [VALUE_BITS-1:0] cv_reg, cv_next, v_reg, v_next;
    logic [1:0]  op_reg, op_next;
    logic        placed_reg, placed_next;
    logic [16:0] count_reg, count_next;
    logic [16:0] load_limit_reg;
    logic [7:0]  probe_limit_reg;
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] value_reg, value_next;
    logic [15:0] slot_reg, slot_next;

    logic hash_start, hash_done;
    logic [IDX_W-1:0] hash_home;
    logic mem_we;
    logic [1:0]  wr_mark, rd_mark;
    logic [63:0] wr_key, rd_key;
    logic [VALUE_BITS-1:0] wr_val, rd_val;
    logic [7:0]  wr_dist, rd_dist;

    logic [IDX_W-1:0] idx_inc;
    logic last_slot, f_empty, f_hit, at_limit, full, miss_ins;
    logic i_free, i_keq, swap, i_over;
    logic [8:0] nd, nd1;

    rhh_hash #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .home  (hash_home)
    );

    rhh_slot_mem #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS), .IDX_W(IDX_W)) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .addr    (idx_reg),
        .wr_mark (wr_mark),
        .wr_key  (wr_key),
        .wr_val  (wr_val),
        .wr_dist (wr_dist),
        .rd_mark (rd_mark),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .rd_dist (rd_dist)
    );

    assign last_slot = idx_reg == IDX_W'(SLOTS - 1);
    assign idx_inc   = last_slot ? '0 : idx_reg + 1'b1;
    assign f_empty   = rd_mark == MARK_EMPTY;
    assign f_hit     = (rd_mark == MARK_USED) && (rd_key == ck_reg);
    assign at_limit  = d_reg == {1'b0, probe_limit_reg};
    assign full      = (count_reg >= load_limit_reg) || (count_reg >= 17'(SLOTS));
    assign miss_ins  = (op_reg == OP_PUT) && !full;
    assign i_free    = rd_mark != MARK_USED;
    assign i_keq     = rd_key == ck_reg;
    assign swap      = {1'b0, rd_dist} < d_reg;
    assign nd        = swap ? {1'b0, rd_dist} : d_reg;
    assign nd1       = nd + 9'd1;
    assign i_over    = nd1 > {1'b0, probe_limit_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (last_slot) state_next = S_IDLE;
            S_IDLE:     if (start) state_next = S_HASH;
            S_HASH:
            begin
                if (hash_done)
                    state_next = (op_reg == OP_NONE) ? S_IDLE : S_FIND_RD;
            end
            S_FIND_RD:  state_next = S_FIND_CMP;
            S_FIND_CMP:
            begin
                if (f_hit)
                    state_next = S_IDLE;
                else if (f_empty || at_limit)
                    state_next = miss_ins ? S_INS_RD : S_IDLE;
                else
                    state_next = S_FIND_RD;
            end
            S_INS_RD:   state_next = S_INS_CMP;
            S_INS_CMP:
            begin
                if (i_free || i_keq || i_over)
                    state_next = S_IDLE;
                else
                    state_next = S_INS_RD;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        home_next   = home_reg;
        pat_next    = pat_reg;
        d_next      = d_reg;
        ck_next     = ck_reg;
        cv_next     = cv_reg;
        v_next      = v_reg;
        op_next     = op_reg;
        placed_next = placed_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        slot_next   = slot_reg;
        hash_start  = 1'b0;
        mem_we      = 1'b0;
        wr_mark     = MARK_USED;
        wr_key      = ck_reg;
        wr_val      = cv_reg;
        wr_dist     = d_reg[7:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_mark  = MARK_EMPTY;
                idx_next = idx_inc;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    ck_next     = key;
                    v_next      = VALUE_BITS'(new_value);
                    cv_next     = VALUE_BITS'(new_value);
                    placed_next = 1'b0;
                    pat_next    = '0;
                    hash_start  = 1'b1;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    if (op_reg == OP_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_NOT_FOUND;
                        value_next  = 32'd0;
                        slot_next   = 16'd0;
                    end
                    idx_next  = hash_home;
                    home_next = hash_home;
                    d_next    = 9'd0;
                end
            end
            S_FIND_CMP:
            begin
                if (f_hit)
                begin
                    done_next  = 1'b1;
                    value_next = 32'(rd_val);
                    slot_next  = 16'(idx_reg);
                    if (op_reg == OP_DEL)
                    begin
                        mem_we      = 1'b1;
                        wr_mark     = MARK_TOMB;
                        wr_key      = rd_key;
                        wr_val      = rd_val;
                        wr_dist     = rd_dist;
                        status_next = STATUS_DELETED;
                        if (count_reg != 17'd0)
                            count_next = count_reg - 17'd1;
                    end
                    else
                    begin
                        status_next = STATUS_FOUND;
                    end
                end
                else if (f_empty || at_limit)
                begin
                    if (miss_ins)
                    begin
                        idx_next = home_reg;
                        d_next   = 9'd0;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = (op_reg == OP_PUT) ? STATUS_LOAD_FULL : STATUS_NOT_FOUND;
                        value_next  = 32'd0;
                        slot_next   = 16'd0;
                    end
                end
                else
                begin
                    d_next   = d_reg + 9'd1;
                    idx_next = idx_inc;
                end
            end
            S_INS_CMP:
            begin
                if (i_free)
                begin
                    mem_we      = 1'b1;
                    count_next  = count_reg + 17'd1;
                    done_next   = 1'b1;
                    status_next = STATUS_INSERTED;
                    value_next  = 32'(v_reg);
                    slot_next   = 16'(placed_reg ? pat_reg : idx_reg);
                end
                else if (i_keq)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_FOUND;
                    value_next  = 32'(rd_val);
                    slot_next   = 16'(idx_reg);
                end
                else
                begin
                    if (swap)
                    begin
                        // displace the richer occupant and carry it on
                        mem_we  = 1'b1;
                        ck_next = rd_key;
                        cv_next = rd_val;
                        if (!placed_reg)
                        begin
                            placed_next = 1'b1;
                            pat_next    = idx_reg;
                        end
                    end
                    d_next   = nd1;
                    idx_next = idx_inc;
                    if (i_over)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_PROBE_LIMIT;
                        value_next  = placed_next ? 32'(v_reg) : 32'd0;
                        slot_next   = placed_next ? 16'(pat_next) : 16'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            idx_reg         <= '0;
            count_reg       <= 17'd0;
            done_reg        <= 1'b0;
            load_limit_reg  <= LOAD_LIMIT_RESET;
            probe_limit_reg <= PROBE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_LOAD_LIMIT:  load_limit_reg  <= cfg_data;
                    REG_PROBE_LIMIT: probe_limit_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg   <= home_next;
        pat_reg    <= pat_next;
        d_reg      <= d_next;
        ck_reg     <= ck_next;
        cv_reg     <= cv_next;
        v_reg      <= v_next;
        op_reg     <= op_next;
        placed_reg <= placed_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = value_reg;
    assign slot_index = slot_reg;

endmodule

>>> hdl/rhh_checker.sv
// Port-level assertions for the hash table, bound to the top level.
// Depends on rhh_pkg and robin_hood_hash_table_macros.svh.
`timescale 1ns / 1ps
`include "robin_hood_hash_table_macros.svh"

module rhh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [31:0] read_value,
    input logic [15:0] slot_index
);
    import rhh_pkg::*;

    `RHH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `RHH_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted two cycles")
    `RHH_ASSERT_NOW(a_status_code, done, status <= STATUS_PROBE_LIMIT, "bad status code")
    `RHH_ASSERT_NOW(a_miss_zero, done && (status == STATUS_NOT_FOUND),
        (read_value == 32'd0) && (slot_index == 16'd0), "miss with nonzero payload")

endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (.*);

>>> sim/tb_robin_hood_hash_table.sv
// Self-checking testbench for robin_hood_hash_table: queue-fed driver, result monitor
// and an in-bench Robin Hood table predictor. Depends on rhh_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_robin_hood_hash_table;
    import rhh_pkg::*;

    localparam int NSLOT = 1024;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] value;
    } request_t;

    typedef struct {
        logic [2:0]  st;
        logic [31:0] val;
        logic [15:0] slot;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = OP_GET;
    logic [63:0] key = '0;
    logic [31:0] new_value = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [15:0] slot_index;
    logic        cfg_write = 1'b0;
    logic        cfg_index = REG_LOAD_LIMIT;
    logic [16:0] cfg_data = '0;

    robin_hood_hash_table DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .key(key),
        .new_value(new_value), .done(done), .status(status), .read_value(read_value),
        .slot_index(slot_index), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // table shadow
    logic [1:0]  tbl_mark [NSLOT];
    logic [63:0] tbl_key  [NSLOT];
    logic [31:0] tbl_val  [NSLOT];
    int          tbl_dist [NSLOT];
    int          tbl_count = 0;
    int          cur_load_limit = LOAD_LIMIT_RESET;
    int          cur_probe_limit = PROBE_LIMIT_RESET;

    request_t    pending_reqs [$];
    answer_t     expected_answers [$];
    logic [63:0] key_pool [$];
    int          issued = 0;
    int          taken = 0;
    int          sender_idle_pct = 0;
    int          errors = 0;

    function automatic int home_slot(input logic [63:0] k);
        logic [63:0] h;
        h = k ^ (k >> MIX_SHIFT);
        h = h * MIX_C1;
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_C2;
        h = h ^ (h >> MIX_SHIFT);
        return int'(h % NSLOT);
    endfunction

    function automatic bit lookup(input logic [63:0] k, output int where);
        int idx;
        idx = home_slot(k);
        where = 0;
        for (int d = 0; d <= cur_probe_limit; d++) begin
            if (tbl_mark[idx] == MARK_EMPTY)
                return 1'b0;
            if (tbl_mark[idx] == MARK_USED && tbl_key[idx] == k) begin
                where = idx;
                return 1'b1;
            end
            idx = (idx + 1) % NSLOT;
        end
        return 1'b0;
    endfunction

    function automatic answer_t robin_insert(input logic [63:0] k, input logic [31:0] v);
        logic [63:0] ck, tk;
        logic [31:0] cv, tv;
        int          cdist, idx, td, placed_at;
        bit          placed;
        answer_t     a;
        ck = k;
        cv = v;
        cdist = 0;
        idx = home_slot(k);
        placed = 1'b0;
        placed_at = 0;
        while (cdist <= cur_probe_limit) begin
            if (tbl_mark[idx] != MARK_USED) begin
                tbl_mark[idx] = MARK_USED;
                tbl_key[idx] = ck;
                tbl_val[idx] = cv;
                tbl_dist[idx] = cdist;
                tbl_count = (tbl_count + 1) & 17'h1ffff;
                if (!placed)
                    placed_at = idx;
                a = '{STATUS_INSERTED, v, 16'(placed_at)};
                return a;
            end
            if (tbl_key[idx] == ck) begin
                a = '{STATUS_FOUND, tbl_val[idx], 16'(idx)};
                return a;
            end
            if (tbl_dist[idx] < cdist) begin
                tk = tbl_key[idx];
                tv = tbl_val[idx];
                td = tbl_dist[idx];
                tbl_key[idx] = ck;
                tbl_val[idx] = cv;
                tbl_dist[idx] = cdist;
                if (!placed) begin
                    placed = 1'b1;
                    placed_at = idx;
                end
                ck = tk;
                cv = tv;
                cdist = td;
            end
            cdist++;
            idx = (idx + 1) % NSLOT;
        end
        if (placed)
            a = '{STATUS_PROBE_LIMIT, v, 16'(placed_at)};
        else
            a = '{STATUS_PROBE_LIMIT, 32'd0, 16'd0};
        return a;
    endfunction

    function automatic answer_t table_step(input request_t r);
        int      where;
        answer_t a;
        a = '{STATUS_NOT_FOUND, 32'd0, 16'd0};
        case (r.op)
            OP_GET: begin
                if (lookup(r.key, where))
                    a = '{STATUS_FOUND, tbl_val[where], 16'(where)};
            end
            OP_PUT: begin
                if (lookup(r.key, where))
                    a = '{STATUS_FOUND, tbl_val[where], 16'(where)};
                else if (tbl_count >= cur_load_limit || tbl_count >= NSLOT)
                    a = '{STATUS_LOAD_FULL, 32'd0, 16'd0};
                else
                    a = robin_insert(r.key, r.value);
            end
            OP_DEL: begin
                if (lookup(r.key, where)) begin
                    tbl_mark[where] = MARK_TOMB;
                    if (tbl_count > 0)
                        tbl_count--;
                    a = '{STATUS_DELETED, tbl_val[where], 16'(where)};
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    initial begin
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_mark[i] = MARK_EMPTY;
            tbl_dist[i] = 0;
        end
    end

    // monitor: results first, then requests and config taken on this edge
    always @(posedge clk)
    begin
        answer_t  want;
        request_t r;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d value=%h slot=%0d",
                             $time, status, read_value, slot_index);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                        errors++;
                    end
                    if (read_value !== want.val)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.val, read_value);
                        errors++;
                    end
                    if (slot_index !== want.slot)
                    begin
                        $display("%0t: slot_index expected %0d actual %0d",
                                 $time, want.slot, slot_index);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                r = '{op, key, new_value};
                expected_answers.push_back(table_step(r));
                taken++;
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_LOAD_LIMIT)
                    cur_load_limit = cfg_data;
                else
                    cur_probe_limit = cfg_data[7:0];
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic     nxt_start;
        request_t r;
        if (rst_n)
        begin
            nxt_start = start;
            if (start && taken == issued)
                nxt_start = 1'b0;
            if (!nxt_start && pending_reqs.size() > 0
                && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                r = pending_reqs.pop_front();
                op <= r.op;
                key <= r.key;
                new_value <= r.value;
                nxt_start = 1'b1;
                issued++;
            end
            start <= nxt_start;
        end
    end

    task automatic push_req(input logic [1:0] o, input logic [63:0] k, input logic [31:0] v);
        request_t r;
        r = '{o, k, v};
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_answers.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic push_random(input int n);
        logic [1:0]  o;
        logic [63:0] k;
        for (int i = 0; i < n; i++)
        begin
            o = ($urandom_range(0, 49) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 3) != 0)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = {$urandom, $urandom};
            push_req(o, k, $urandom);
        end
    endtask

    initial begin
        for (int i = 0; i < 300; i++)
            key_pool.push_back({$urandom, $urandom});
        key_pool.push_back(64'd0);
        key_pool.push_back('1);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        sender_idle_pct = 20;
        push_req(OP_NONE, 64'h1234, 32'h55);
        push_req(OP_GET, 64'd0, 32'd0);
        push_req(OP_DEL, 64'd0, 32'd0);
        push_req(OP_PUT, 64'd0, 32'hffffffff);
        push_req(OP_PUT, 64'd0, 32'h1);
        push_req(OP_GET, 64'd0, 32'd0);
        push_req(OP_PUT, '1, 32'd0);
        push_req(OP_GET, '1, 32'd0);
        push_req(OP_DEL, 64'd0, 32'd0);
        push_req(OP_GET, 64'd0, 32'd0);
        push_req(OP_DEL, 64'd0, 32'd0);
        push_req(OP_PUT, 64'd0, 32'habcd);
        push_req(OP_DEL, '1, 32'd0);
        drain();

        push_random(150);
        drain();
        push_random(140);
        drain();

        // tiny limits: load full and probe limit
        write_reg(REG_LOAD_LIMIT, 17'd1);
        write_reg(REG_PROBE_LIMIT, 17'd1);
        sender_idle_pct = 54;
        push_req(OP_PUT, 64'h77, 32'h9);
        push_random(200);
        drain();

        write_reg(REG_LOAD_LIMIT, 17'd65536);
        write_reg(REG_PROBE_LIMIT, 17'd1);
        push_random(150);
        drain();

        write_reg(REG_LOAD_LIMIT, 17'd65536);
        write_reg(REG_PROBE_LIMIT, 17'd254);
        sender_idle_pct = 0;
        push_random(250);
        drain();

        write_reg(REG_LOAD_LIMIT, 17'd300);
        write_reg(REG_PROBE_LIMIT, 17'd3);
        push_random(250);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
